@@ sv/bbpt_pkg.sv @@
// Shared types and reset constants for the beep burst pattern timer.
package bbpt_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned RepW   = 8;
  localparam int unsigned TotalW = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned AddrW  = 2;
  localparam int unsigned InW    = 8;
  localparam int unsigned OutW   = 40;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_BEEP  = 2'd2,
    PH_PAUSE = 2'd3
  } phase_t;

  typedef enum logic [AddrW-1:0] {
    REG_PERIOD   = 2'd0,
    REG_DURATION = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_PAUSE    = 2'd3
  } reg_index_t;

  localparam logic [TickW-1:0] PeriodReset   = 16'd1000;
  localparam logic [TickW-1:0] DurationReset = 16'd250;
  localparam logic [RepW-1:0]  RepeatReset   = 8'd1;
  localparam logic [TickW-1:0] PauseReset    = 16'd0;

  typedef struct packed {
    logic [TickW-1:0] period_ticks;
    logic [TickW-1:0] duration_ticks;
    logic [RepW-1:0]  repeat_count;
    logic [TickW-1:0] pause_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TotalW-1:0] beeps_done;
    logic              beep_on;
  } result_t;

endpackage

@@ sv/bbpt_regs.sv @@
// Configuration register file of the beep burst pattern timer.
module bbpt_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bbpt_pkg::AddrW-1:0]  cfg_addr,
  input  logic [bbpt_pkg::CfgW-1:0]   cfg_data,
  output bbpt_pkg::cfg_t              cfg
);
  import bbpt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks   <= PeriodReset;
      cfg.duration_ticks <= DurationReset;
      cfg.repeat_count   <= RepeatReset;
      cfg.pause_ticks    <= PauseReset;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_PERIOD:   cfg.period_ticks   <= cfg_data;
        REG_DURATION: cfg.duration_ticks <= cfg_data;
        REG_REPEAT:   cfg.repeat_count   <= cfg_data[RepW-1:0];
        REG_PAUSE:    cfg.pause_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/bbpt_core.sv @@
// Phase sequencer: updates timer state once per accepted tick request.
module bbpt_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              active,
  input  logic              started,
  input  bbpt_pkg::cfg_t    cfg,
  output bbpt_pkg::result_t result
);
  import bbpt_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [TickW-1:0]  tick;
  logic [TickW-1:0]  tick_next;
  logic [RepW-1:0]   rep;
  logic [RepW-1:0]   rep_next;
  logic [TotalW-1:0] total;
  logic [TotalW-1:0] total_next;

  logic              run;
  logic [TickW-1:0]  pause_len;
  logic [TickW:0]    tick_inc;
  logic              wait_done;
  logic              beep_done;
  logic              pause_done;
  phase_t            end_phase;

  always_comb begin
    run = active & started;
    // pause minus period, saturated at zero
    if (cfg.pause_ticks > cfg.period_ticks) begin
      pause_len = cfg.pause_ticks - cfg.period_ticks;
    end else begin
      pause_len = '0;
    end
    end_phase  = (pause_len != '0) ? PH_PAUSE : PH_IDLE;
    tick_inc   = {1'b0, tick} + {{TickW{1'b0}}, 1'b1};
    wait_done  = tick_inc >= {1'b0, cfg.period_ticks};
    beep_done  = tick_inc >= {1'b0, cfg.duration_ticks};
    pause_done = tick_inc >= {1'b0, pause_len};

    phase_next = phase;
    tick_next  = tick;
    rep_next   = rep;
    total_next = total;
    case (phase)
      PH_IDLE: begin
        if (run) begin
          rep_next   = '0;
          tick_next  = '0;
          phase_next = (cfg.repeat_count != '0) ? PH_WAIT : end_phase;
        end
      end
      PH_WAIT: begin
        if (!run) begin
          tick_next  = '0;
          phase_next = end_phase;
        end else if (wait_done) begin
          total_next = total + 1'b1;
          rep_next   = rep + 1'b1;
          tick_next  = '0;
          phase_next = PH_BEEP;
        end else begin
          tick_next = tick_inc[TickW-1:0];
        end
      end
      PH_BEEP: begin
        if (beep_done) begin
          tick_next  = '0;
          phase_next = (rep < cfg.repeat_count) ? PH_WAIT : end_phase;
        end else begin
          tick_next = tick_inc[TickW-1:0];
        end
      end
      PH_PAUSE: begin
        if (pause_done) begin
          tick_next  = '0;
          phase_next = PH_IDLE;
        end else begin
          tick_next = tick_inc[TickW-1:0];
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    result.phase      = phase_next;
    result.beeps_done = total_next;
    result.beep_on    = (phase_next == PH_BEEP) && (cfg.duration_ticks != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick  <= '0;
      rep   <= '0;
      total <= '0;
    end else if (step) begin
      phase <= phase_next;
      tick  <= tick_next;
      rep   <= rep_next;
      total <= total_next;
    end
  end

endmodule

@@ sv/bbpt_out.sv @@
// Result register with skid stage between the sequencer and the output stream.
module bbpt_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  bbpt_pkg::result_t in_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bbpt_pkg::result_t out_data
);
  import bbpt_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        if (in_valid) begin
          out_data <= in_data;
        end
      end
    end else if (in_valid && in_ready) begin
      // hold the new result while the output stalls
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

@@ sv/beep_burst_pattern_timer.sv @@
// Beep burst pattern timer: one tick request in, one result out per tick.
// The result of a tick reaches m_tdata through the output register, or via the skid register when the output stalls.
// Throughput: one tick per cycle while s_tready is high, with one phase sequencer update per accepted tick.
// A two-entry output stage keeps s_tready high for one stalled result.
// Reset (rst, synchronous): idle phase, counters zero, registers to defaults.
module beep_burst_pattern_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bbpt_pkg::InW-1:0]    s_tdata,  // [0] active, [1] started, rest zero
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bbpt_pkg::OutW-1:0]   m_tdata,  // [0] beep_on, [32:1] beeps_done,
                                                // [34:33] phase, rest zero
  input  logic                        cfg_we,
  input  logic [bbpt_pkg::AddrW-1:0]  cfg_addr,
  input  logic [bbpt_pkg::CfgW-1:0]   cfg_data
);
  import bbpt_pkg::*;

  cfg_t    cfg;
  result_t core_result;
  result_t out_result;
  logic    step;

  assign step = s_tvalid && s_tready;

  bbpt_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bbpt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .active  (s_tdata[0]),
    .started (s_tdata[1]),
    .cfg     (cfg),
    .result  (core_result)
  );

  bbpt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_data   (core_result),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {5'b0, out_result.phase, out_result.beeps_done, out_result.beep_on};

endmodule
